// ===== rtl/mi4_pkg.sv =====
// Shared types, constants and index helpers for the 4x4 matrix inverter.
package mi4_pkg;

    localparam int DEF_WORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int IDX_W          = 4;
    localparam int VAL_W          = 32;
    localparam int NUM_TERMS      = 6;
    localparam int DET_ROWS       = 4;
    localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

    typedef enum logic [3:0] {
        S_LOAD,
        S_FETCH,
        S_TAKE,
        S_MUL,
        S_ADD,
        S_ACC,
        S_OFETCH,
        S_OTAKE,
        S_DIVW,
        S_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_PREP,
        DV_STEP,
        DV_RND
    } div_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // j-th index of 0..3 with x removed
    function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] j);
        logic [1:0] r;
        r = (j < x) ? j : j + 2'd1;
        return r;
    endfunction

    // column permutation of one 3x3 determinant term, packed {p2, p1, p0}
    function automatic logic [1:0] term_col(input logic [2:0] t, input logic [1:0] j);
        logic [5:0] p;
        case (t)
            3'd0: p = {2'd2, 2'd1, 2'd0};
            3'd1: p = {2'd1, 2'd2, 2'd0};
            3'd2: p = {2'd2, 2'd0, 2'd1};
            3'd3: p = {2'd0, 2'd2, 2'd1};
            3'd4: p = {2'd1, 2'd0, 2'd2};
            3'd5: p = {2'd0, 2'd1, 2'd2};
            default: p = '0;
        endcase
        return p[2*j +: 2];
    endfunction

    function automatic logic term_neg(input logic [2:0] t);
        logic n;
        case (t)
            3'd1, 3'd2, 3'd5: n = 1'b1;
            default: n = 1'b0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/matrix_inverse_4x4.sv =====
// 4x4 fixed-point matrix inverse by cofactors and adjugate (top level).
// Elements arrive column-major (index = row + 4*column) as signed Q(W-F).F words
// and are written into a 16-word matrix memory; the transfer carrying index 15
// starts the run and input is held off until the sixteenth result has been
// produced. The 16 cofactors are formed from 96 three-element products through one
// shared multiplier fed by the matrix memory's single read port and are kept in a
// 16-entry cofactor memory; the determinant is formed after them. Each result then
// goes through a restoring divider at one quotient bit per cycle.
// A zero determinant returns the stored matrix with the singular flag set.
module matrix_inverse_4x4 #(
    parameter int WORD_WIDTH = mi4_pkg::DEF_WORD_WIDTH,
    parameter int FRAC_BITS  = mi4_pkg::DEF_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // element_index[3:0], element_value[35:4]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_index[3:0], result_value[35:4]
    output logic [1:0]  m_tuser,   // singular[0], saturated[1]
    output logic        m_tlast
);
    import mi4_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int CW = 3 * W + 3;
    localparam int DW = 4 * W + 5;
    localparam int TW = 4 * W;
    localparam int PW = 5 * W;

    seq_state_t state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [2:0]       term_reg, term_next;
    logic [1:0]       fac_reg, fac_next;
    logic [1:0]       chunk_reg, chunk_next;
    logic             first_reg, first_next;
    logic             dphase_reg, dphase_next;
    logic signed [TW-1:0] t_reg, t_next;
    logic [W-1:0]         e_reg, e_next;
    logic signed [2*W:0]  mp_reg, mp_next;
    logic signed [PW-1:0] p_reg, p_next, p_new;
    logic [CW-1:0]        cacc_reg, cacc_next;
    logic signed [DW-1:0] det_reg, det_next;
    logic [W-1:0]         rv_reg, rv_next;
    logic                 rsat_reg, rsat_next;
    logic                 ov_reg, ov_next;
    logic [IDX_W-1:0]     oidx_reg, oidx_next;
    logic [VAL_W-1:0]     oval_reg, oval_next;
    logic                 osing_reg, osing_next;
    logic                 osat_reg, osat_next;
    logic                 olast_reg, olast_next;

    logic             mat_we, mat_re, cof_we, cof_re;
    logic [IDX_W-1:0] mat_raddr, cof_raddr;
    logic [W-1:0]     mat_q;
    logic [CW-1:0]    cof_q;
    logic             div_start;
    div_stat_t        div_stat;
    logic [W-1:0]     div_value;
    logic             div_sat;

    logic [1:0]   row, col;
    logic         cneg, sing, csign, in_xfer;
    logic [W-1:0] tch;

    assign in_xfer = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_LOAD);
    assign mat_we  = in_xfer;

    assign row   = skip_idx(k_reg[3:2], fac_reg);
    assign col   = skip_idx(k_reg[1:0], term_col(term_reg, fac_reg));
    assign cneg  = term_neg(term_reg) ^ k_reg[2] ^ k_reg[0];
    assign sing  = (det_reg == '0);
    assign tch   = t_reg[chunk_reg*W +: W];
    assign csign = first_reg & tch[W-1];
    assign mp_next = $signed({csign, tch}) * $signed(e_reg);
    assign p_new = (p_reg <<< W) + PW'(mp_reg);

    mi4_ram #(.DATA_W(W), .ADDR_W(IDX_W)) u_mat (
        .aclk  (aclk),
        .we    (mat_we),
        .waddr (s_tdata[3:0]),
        .wdata (s_tdata[W+3:4]),
        .re    (mat_re),
        .raddr (mat_raddr),
        .rdata (mat_q)
    );

    mi4_ram #(.DATA_W(CW), .ADDR_W(IDX_W)) u_cof (
        .aclk  (aclk),
        .we    (cof_we),
        .waddr (k_reg),
        .wdata (cacc_next),
        .re    (cof_re),
        .raddr (cof_raddr),
        .rdata (cof_q)
    );

    mi4_div #(.W(W), .F(FRAC_BITS), .CW(CW), .DW(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .cof     (cof_q),
        .det     (det_reg),
        .stat    (div_stat),
        .value   (div_value),
        .sat     (div_sat)
    );

    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        term_next   = term_reg;
        fac_next    = fac_reg;
        chunk_next  = chunk_reg;
        first_next  = first_reg;
        dphase_next = dphase_reg;
        t_next      = t_reg;
        e_next      = e_reg;
        p_next      = p_reg;
        cacc_next   = cacc_reg;
        det_next    = det_reg;
        rv_next     = rv_reg;
        rsat_next   = rsat_reg;
        ov_next     = ov_reg & ~m_tready;
        oidx_next   = oidx_reg;
        oval_next   = oval_reg;
        osing_next  = osing_reg;
        osat_next   = osat_reg;
        olast_next  = olast_reg;
        mat_re      = 1'b0;
        cof_re      = 1'b0;
        cof_we      = 1'b0;
        mat_raddr   = {col, row};
        cof_raddr   = k_reg;
        div_start   = 1'b0;
        case (state_reg)
            S_LOAD: begin
                if (in_xfer && s_tdata[3:0] == LAST_IDX) begin
                    k_next      = '0;
                    term_next   = '0;
                    fac_next    = '0;
                    dphase_next = 1'b0;
                    cacc_next   = '0;
                    det_next    = '0;
                    state_next  = S_FETCH;
                end
            end
            S_FETCH: begin
                if (dphase_reg) begin
                    mat_raddr = {2'b00, k_reg[1:0]};
                    cof_raddr = {k_reg[1:0], 2'b00};
                    mat_re    = (fac_reg != 2'd0);
                    cof_re    = (fac_reg == 2'd0);
                end else begin
                    mat_re    = 1'b1;
                end
                state_next = S_TAKE;
            end
            S_TAKE: begin
                if (fac_reg == 2'd0) begin
                    t_next     = dphase_reg ? TW'(signed'(cof_q)) : TW'(signed'(mat_q));
                    if (!dphase_reg && term_reg == 3'd0) begin
                        cacc_next = '0;
                    end
                    fac_next   = 2'd1;
                    state_next = S_FETCH;
                end else begin
                    e_next     = mat_q;
                    chunk_next = dphase_reg ? 2'd3 : ((fac_reg == 2'd1) ? 2'd0 : 2'd1);
                    first_next = 1'b1;
                    p_next     = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                state_next = S_ADD;
            end
            S_ADD: begin
                p_next     = p_new;
                first_next = 1'b0;
                if (chunk_reg == 2'd0) begin
                    t_next = p_new[TW-1:0];
                    if (!dphase_reg && fac_reg == 2'd1) begin
                        fac_next   = 2'd2;
                        state_next = S_FETCH;
                    end else begin
                        state_next = S_ACC;
                    end
                end else begin
                    chunk_next = chunk_reg - 1'b1;
                    state_next = S_MUL;
                end
            end
            S_ACC: begin
                fac_next   = '0;
                state_next = S_FETCH;
                if (dphase_reg) begin
                    det_next = det_reg + p_reg[DW-1:0];
                    if (k_reg[1:0] == 2'(DET_ROWS - 1)) begin
                        k_next     = '0;
                        state_next = S_OFETCH;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end else begin
                    cacc_next = cneg ? cacc_reg - p_reg[CW-1:0] : cacc_reg + p_reg[CW-1:0];
                    if (term_reg == 3'(NUM_TERMS - 1)) begin
                        cof_we    = 1'b1;
                        term_next = '0;
                        if (k_reg == LAST_IDX) begin
                            k_next      = '0;
                            dphase_next = 1'b1;
                        end else begin
                            k_next = k_reg + 1'b1;
                        end
                    end else begin
                        term_next = term_reg + 1'b1;
                    end
                end
            end
            S_OFETCH: begin
                mat_raddr  = k_reg;
                mat_re     = sing;
                cof_re     = ~sing;
                state_next = S_OTAKE;
            end
            S_OTAKE: begin
                if (sing) begin
                    rv_next    = mat_q;
                    rsat_next  = 1'b0;
                    state_next = S_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div_stat.done) begin
                    rv_next    = div_value;
                    rsat_next  = div_sat;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!ov_reg || m_tready) begin
                    ov_next    = 1'b1;
                    oidx_next  = k_reg;
                    oval_next  = VAL_W'(signed'(rv_reg));
                    osing_next = sing;
                    osat_next  = rsat_reg;
                    olast_next = (k_reg == LAST_IDX);
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg == LAST_IDX) ? S_LOAD : S_OFETCH;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        term_reg   <= term_next;
        fac_reg    <= fac_next;
        chunk_reg  <= chunk_next;
        first_reg  <= first_next;
        dphase_reg <= dphase_next;
        t_reg      <= t_next;
        e_reg      <= e_next;
        mp_reg     <= mp_next;
        p_reg      <= p_next;
        cacc_reg   <= cacc_next;
        det_reg    <= det_next;
        rv_reg     <= rv_next;
        rsat_reg   <= rsat_next;
        oidx_reg   <= oidx_next;
        oval_reg   <= oval_next;
        osing_reg  <= osing_next;
        osat_reg   <= osat_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'b0000, oval_reg, oidx_reg};
    assign m_tuser  = {osat_reg, osing_reg};
    assign m_tlast  = olast_reg;

`ifndef SYNTH
    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == S_DIVW)
        else $error("divider finished outside its wait state");
    a_cof_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        cof_we |-> !dphase_reg)
        else $error("cofactor memory written during determinant phase");
    a_sing_no_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("singular result flagged saturated");
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[3:0] == LAST_IDX)
        else $error("last transfer without final index");
    a_load_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("input taken while divider busy");
`endif
endmodule

// ===== rtl/mi4_ram.sv =====
// Single-port-write, registered-read memory.
module mi4_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/mi4_div.sv =====
// Restoring divider: round(cof * 2^(2F) / det) with saturation to W bits.
module mi4_div #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int CW = 99,
    parameter int DW = 133
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [CW-1:0] cof,
    input  logic signed [DW-1:0] det,
    output mi4_pkg::div_stat_t   stat,
    output logic [W-1:0]         value,
    output logic                 sat
);
    import mi4_pkg::*;

    localparam int XW  = ((DW + W + 1) > (CW + 2 * F)) ? (DW + W + 1) : (CW + 2 * F);
    localparam int CNW = $clog2(W + 1);

    div_state_t state_reg, state_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [XW-1:0]  rem_reg, rem_next;
    logic [XW-1:0]  dsh_reg, dsh_next;
    logic [XW-1:0]  den_reg, den_next;
    logic [W:0]     q_reg, q_next;
    logic           neg_reg, neg_next;
    logic           ovf_reg, ovf_next;

    logic signed [XW-1:0] cof_x, det_x;
    logic                 ge, rbit;
    logic [W+1:0]         qr, lim, mag, sval;

    assign cof_x = XW'(cof);
    assign det_x = XW'(det);
    assign ge    = rem_reg >= dsh_reg;
    assign rbit  = {rem_reg, 1'b0} >= {1'b0, den_reg};
    assign qr    = {1'b0, q_reg} + (W + 2)'(rbit);
    assign lim   = neg_reg ? ((W + 2)'(1) << (W - 1)) : (((W + 2)'(1) << (W - 1)) - 1'b1);
    assign sat   = ovf_reg | (qr > lim);
    assign mag   = sat ? lim : qr;
    assign sval  = neg_reg ? (~mag + 1'b1) : mag;
    assign value = sval[W-1:0];

    assign stat.busy = (state_reg != DV_IDLE);
    assign stat.done = (state_reg == DV_RND);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            DV_IDLE: begin
                if (start) begin
                    neg_next   = (cof[CW-1] ^ det[DW-1]) && (cof != '0);
                    rem_next   = (cof[CW-1] ? -cof_x : cof_x) << (2 * F);
                    den_next   = det[DW-1] ? -det_x : det_x;
                    state_next = DV_PREP;
                end
            end
            DV_PREP: begin
                ovf_next   = rem_reg >= (den_reg << (W + 1));
                dsh_next   = den_reg << W;
                cnt_next   = CNW'(W);
                q_next     = '0;
                state_next = DV_STEP;
            end
            DV_STEP: begin
                rem_next = ge ? rem_reg - dsh_reg : rem_reg;
                q_next   = {q_reg[W-1:0], ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = DV_RND;
                end
            end
            DV_RND: begin
                state_next = DV_IDLE;
            end
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
    end
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the 4x4 fixed-point matrix inverter.
`timescale 1ns / 1ps

module testbench;
    import mi4_pkg::*;

    localparam int WW = DEF_WORD_WIDTH;
    localparam int FB = DEF_FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 400;
    localparam logic [31:0] ONE_Q = 32'h0001_0000;

    typedef logic signed [191:0] wide_t;
    typedef struct packed {
        logic [3:0]  idx;
        logic [31:0] value;
        logic        singular;
        logic        saturated;
        logic        last;
    } inv_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    logic [31:0]  model_matrix [16];
    inv_result_t  inverse_q [$];
    int           errors = 0;
    int           idle_cycles = 0;
    int           hold_requests = 0;
    int           hold_served = 0;
    int           hold_left = 0;
    int           burst_left = 0;
    bit           quiet = 0;
    int           tx_gap = 0;

    matrix_inverse_4x4 dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic wide_t entry(int r, int c);
        return wide_t'($signed(model_matrix[r + 4 * c]));
    endfunction

    function automatic wide_t cofactor(int dr, int dc);
        int rs [3];
        int cs [3];
        int n;
        wide_t t;
        n = 0;
        for (int k = 0; k < 4; k++) if (k != dr) begin rs[n] = k; n++; end
        n = 0;
        for (int k = 0; k < 4; k++) if (k != dc) begin cs[n] = k; n++; end
        t = entry(rs[0], cs[0]) * (entry(rs[1], cs[1]) * entry(rs[2], cs[2])
                                 - entry(rs[1], cs[2]) * entry(rs[2], cs[1]))
          - entry(rs[0], cs[1]) * (entry(rs[1], cs[0]) * entry(rs[2], cs[2])
                                 - entry(rs[1], cs[2]) * entry(rs[2], cs[0]))
          + entry(rs[0], cs[2]) * (entry(rs[1], cs[0]) * entry(rs[2], cs[1])
                                 - entry(rs[1], cs[1]) * entry(rs[2], cs[0]));
        return ((dr + dc) % 2) ? -t : t;
    endfunction

    task automatic predict_inverse();
        wide_t cof [16];
        wide_t det;
        logic [191:0] num, den, q, rem, lim;
        bit neg;
        inv_result_t res;
        for (int k = 0; k < 16; k++) cof[k] = cofactor(k / 4, k % 4);
        det = 0;
        for (int k = 0; k < 4; k++) det = det + entry(k, 0) * cof[4 * k];
        for (int k = 0; k < 16; k++) begin
            res.idx = k[3:0];
            res.last = (k == 15);
            res.saturated = 1'b0;
            if (det == 0) begin
                res.value = model_matrix[k];
                res.singular = 1'b1;
            end else begin
                res.singular = 1'b0;
                neg = (cof[k] < 0) != (det < 0);
                if (cof[k] == 0) neg = 0;
                num = (cof[k] < 0) ? -cof[k] : cof[k];
                num = num << (2 * FB);
                den = (det < 0) ? -det : det;
                q = num / den;
                rem = num % den;
                if ((rem << 1) >= den) q = q + 1;
                lim = 192'd1 << (WW - 1);
                if (!neg) lim = lim - 1;
                if (q > lim) begin
                    q = lim;
                    res.saturated = 1'b1;
                end
                res.value = neg ? 32'(-q) : q[31:0];
            end
            inverse_q.push_back(res);
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_element(logic [3:0] idx, logic [31:0] value);
        if (!quiet && tx_gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (tx_gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, value, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_matrix[idx] = value;
        if (idx == LAST_IDX) predict_inverse();
        tx_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    endtask

    task automatic send_matrix(logic [31:0] m [16]);
        for (int k = 0; k < 16; k++) send_element(k[3:0], m[k]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2:    return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3:    return 32'h0;
            default: return 32'($signed($urandom_range(0, 20 * ONE_Q)) - 10 * ONE_Q);
        endcase
    endfunction

    function automatic void random_matrix(output logic [31:0] m [16]);
        int c;
        for (int k = 0; k < 16; k++) m[k] = random_value();
        if ($urandom_range(0, 5) == 0) begin
            c = $urandom_range(1, 3);
            for (int r = 0; r < 4; r++) m[r + 4 * c] = m[r];
        end
    endfunction

    task automatic test_identity();
        logic [31:0] m [16];
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? ONE_Q : 32'h0;
        send_matrix(m);
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'hFFFE_0000 : 32'h0;
        m[4] = 32'h0003_8000;
        send_matrix(m);
    endtask

    task automatic test_singular();
        logic [31:0] m [16];
        for (int k = 0; k < 16; k++) m[k] = 32'h0;
        send_matrix(m);
        for (int k = 0; k < 16; k++) m[k] = 32'h1234_5678 ^ (k << 4);
        for (int r = 0; r < 4; r++) m[r + 8] = m[r + 4];
        send_matrix(m);
    endtask

    task automatic test_extremes();
        logic [31:0] m [16];
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        send_matrix(m);
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h8000_0000 : 32'hFFFF_FFFF;
        send_matrix(m);
    endtask

    task automatic test_saturation();
        logic [31:0] m [16];
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h1 : 32'h0;
        m[5] = 32'hFFFF_FFFF;
        send_matrix(m);
    endtask

    task automatic test_partial_update();
        send_element(4'd6, 32'h0002_0000);
        send_element(4'd15, 32'hFFFF_8000);
    endtask

    task automatic test_backpressure();
        logic [31:0] m [16];
        wait_drained();
        hold_requests++;
        random_matrix(m);
        send_matrix(m);
        send_element(4'd3, random_value());
        send_element(4'd15, random_value());
    endtask

    task automatic test_random(int count);
        logic [31:0] m [16];
        int sent;
        int n;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    n = $urandom_range(1, 8);
                    for (int k = 0; k < n; k++)
                        send_element(4'($urandom_range(0, 14)), random_value());
                    send_element(4'd15, random_value());
                    sent += n + 1;
                end
                2: begin
                    n = $urandom_range(1, 4);
                    for (int k = 0; k < n; k++)
                        send_element(4'($urandom_range(0, 14)), random_value());
                    sent += n;
                end
                default: begin
                    random_matrix(m);
                    send_matrix(m);
                    sent += 16;
                end
            endcase
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left <= LONG_HOLD;
        end else if (burst_left > 0) begin
            m_tready <= 1'b0;
            burst_left <= burst_left - 1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            burst_left <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        inv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (inverse_q.size() == 0) begin
                report("unexpected transfer", m_tdata[35:4], 32'h0);
            end else begin
                want = inverse_q.pop_front();
                if (m_tdata[3:0] != want.idx)
                    report("result_index", 32'(m_tdata[3:0]), 32'(want.idx));
                if (m_tdata[35:4] != want.value)
                    report("result_value", m_tdata[35:4], want.value);
                if (m_tuser[0] != want.singular)
                    report("singular", 32'(m_tuser[0]), 32'(want.singular));
                if (m_tuser[1] != want.saturated)
                    report("saturated", 32'(m_tuser[1]), 32'(want.saturated));
                if (m_tlast != want.last)
                    report("last_result", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_identity();
        test_singular();
        test_extremes();
        test_saturation();
        test_partial_update();
        test_backpressure();
        test_random(170);
        quiet = 1;
        test_random(40);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (2000) @(posedge aclk);
        if (errors == 0 && inverse_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mi4_pkg.sv
rtl/mi4_ram.sv
rtl/mi4_div.sv
rtl/matrix_inverse_4x4.sv
sim/testbench.sv
